// ===== sv/htr_pkg.sv =====
// Shared types, constants and lookup functions of the heater regulator.
// Depends on nothing; the controller, datapath and top level refer to it by scoped names.
`default_nettype none

package htr_pkg;

   localparam int WINDOW_HALF_CYCLES_DEF = 100;
   localparam int SUM_WIDTH_DEF          = 32;

   localparam int CHUNK_W = 16;
   localparam int GAIN_W  = 24;
   localparam int ACC_W   = 64;

   localparam logic signed [ACC_W-1:0] FULL_ACC  = 64'sd39321600;
   localparam logic [6:0]              POWER_MAX = 7'd100;
   localparam logic [3:0]              DIV_LAST  = 4'd15;

   localparam logic [1:0] MODE_OFF  = 2'd0;
   localparam logic [1:0] MODE_FULL = 2'd1;
   localparam logic [1:0] MODE_RAMP = 2'd2;

   localparam logic [2:0] REG_RUN_MODE     = 3'd0;
   localparam logic [2:0] REG_TARGET_TEMP  = 3'd1;
   localparam logic [2:0] REG_RAMP_SECONDS = 3'd2;
   localparam logic [2:0] REG_P_GAIN       = 3'd3;
   localparam logic [2:0] REG_I_GAIN       = 3'd4;
   localparam logic [2:0] REG_D_GAIN       = 3'd5;

   localparam logic [1:0] TERM_P = 2'd0;
   localparam logic [1:0] TERM_I = 2'd1;
   localparam logic [1:0] TERM_D = 2'd2;

   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_RESTART = 2'd1,
      CMD_CROSS   = 2'd2,
      CMD_NOP     = 2'd3
   } cmd_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_FAULT,
      OP_RESTART,
      OP_CROSS,
      OP_OFF,
      OP_FS_START,
      OP_FS_HOLD,
      OP_FS_FULL,
      OP_RAMP_START,
      OP_DIV_STEP,
      OP_DIV_END,
      OP_RAMP_ADV,
      OP_PID_BEGIN,
      OP_MUL,
      OP_TERM_END,
      OP_PID_END
   } op_type;

   typedef struct packed {
      logic [1:0]  run_mode;
      logic [7:0]  target_temp;
      logic [15:0] ramp_seconds;
      logic [23:0] p_gain;
      logic [23:0] i_gain;
      logic [23:0] d_gain;
   } cfg_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] term;
      logic [1:0] chunk;
   } dp_cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic       fault;
      logic [1:0] run_mode;
      logic       started;
      logic       band_reached;
      logic       hold_nz;
   } dp_status_type;

   typedef struct packed {
      logic [6:0] heater_power;
      logic       gate_on;
      logic       sensor_fault;
      logic [7:0] ramp_target;
   } result_type;

   typedef struct packed {
      logic [8:0] hold;
      logic [4:0] band;
   } approach_type;

   // Hold count and approach band chosen by setpoint bracket.
   function automatic approach_type approach_lookup(input logic [7:0] sp);
      approach_type r;
      if (sp < 8'd50)       r = '{hold: 9'd270, band: 5'd13};
      else if (sp < 8'd60)  r = '{hold: 9'd265, band: 5'd17};
      else if (sp < 8'd70)  r = '{hold: 9'd260, band: 5'd18};
      else if (sp < 8'd80)  r = '{hold: 9'd255, band: 5'd18};
      else if (sp < 8'd90)  r = '{hold: 9'd250, band: 5'd17};
      else if (sp < 8'd100) r = '{hold: 9'd245, band: 5'd16};
      else if (sp < 8'd110) r = '{hold: 9'd240, band: 5'd16};
      else if (sp < 8'd120) r = '{hold: 9'd230, band: 5'd16};
      else if (sp < 8'd130) r = '{hold: 9'd210, band: 5'd15};
      else if (sp < 8'd140) r = '{hold: 9'd190, band: 5'd15};
      else                  r = '{hold: 9'd170, band: 5'd12};
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== sv/htr_req_if.sv =====
// Request channel of the heater regulator: valid/ready plus one input item.
// Depends on nothing.
`default_nettype none

interface htr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [15:0] sensor_word;

   modport source (output valid, output cmd, output sensor_word, input ready);
   modport sink   (input valid, input cmd, input sensor_word, output ready);
endinterface

`default_nettype wire

// ===== sv/htr_rsp_if.sv =====
// Result channel of the heater regulator: valid/ready plus one result item.
// Depends on nothing.
`default_nettype none

interface htr_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] heater_power;
   logic       gate_on;
   logic       sensor_fault;
   logic [7:0] ramp_target;

   modport source (output valid, output heater_power, output gate_on,
                   output sensor_fault, output ramp_target, input ready);
   modport sink   (input valid, input heater_power, input gate_on,
                   input sensor_fault, input ramp_target, output ready);
endinterface

`default_nettype wire

// ===== sv/htr_dpath.sv =====
// Datapath of the heater regulator: regulation state, PID multiply-accumulate,
// ramp divider and triac window. Depends on htr_pkg; driven by htr_ctrl.
`default_nettype none

module htr_dpath #(
   parameter int WINDOW_HALF_CYCLES = htr_pkg::WINDOW_HALF_CYCLES_DEF,
   parameter int SUM_WIDTH          = htr_pkg::SUM_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire htr_pkg::cfg_type      cfg,
   input  wire logic                  mode_wr,
   input  wire logic [1:0]            req_cmd,
   input  wire logic [15:0]           req_word,
   input  wire htr_pkg::dp_cmd_type   ctl,
   output htr_pkg::dp_status_type     status,
   output htr_pkg::result_type        result
);

   localparam int NCH    = (SUM_WIDTH + htr_pkg::CHUNK_W - 1) / htr_pkg::CHUNK_W;
   localparam int MAG_W  = NCH * htr_pkg::CHUNK_W;
   localparam int PROD_W = htr_pkg::GAIN_W + MAG_W;
   localparam int CMP_W  = (PROD_W > htr_pkg::ACC_W) ? PROD_W : htr_pkg::ACC_W;
   localparam logic [CMP_W-1:0] SAT_MAG = CMP_W'(1) << 62;
   localparam logic [6:0]       WIN_END = 7'(WINDOW_HALF_CYCLES);

   // registers
   logic [1:0]                  cmd_ff, cmd_in;
   logic [15:0]                 word_ff, word_in;
   logic                        started_ff, started_in;
   logic signed [SUM_WIDTH-1:0] sum_ff, sum_in;
   logic signed [13:0]          last_err_ff, last_err_in;
   logic                        windup_ff, windup_in;
   logic [8:0]                  hold_ff, hold_in;
   logic [4:0]                  band_ff, band_in;
   logic [7:0]                  setpoint_ff, setpoint_in;
   logic [15:0]                 ticks_ff, ticks_in;
   logic [15:0]                 phase_ff, phase_in;
   logic [15:0]                 step_ff, step_in;
   logic [6:0]                  power_ff, power_in;
   logic [6:0]                  half_ff, half_in;
   logic                        gate_ff, gate_in;
   logic                        fault_ff, fault_in;
   logic signed [13:0]          err_ff, err_in;
   logic signed [14:0]          dif_ff, dif_in;
   logic [PROD_W-1:0]           prod_ff, prod_in;
   logic signed [63:0]          acc_ff, acc_in;
   logic [15:0]                 quot_ff, quot_in;
   logic [7:0]                  rem_ff, rem_in;
   logic [7:0]                  divisor_ff, divisor_in;

   // combinational helpers
   logic [12:0]                 temp_q;
   logic [10:0]                 deg;
   logic signed [9:0]           bound;
   logic                        band_reached;
   logic [7:0]                  sp_sel;
   logic signed [14:0]          err_wide;
   logic signed [13:0]          err_new;
   logic signed [SUM_WIDTH:0]   sum_ext;
   logic signed [SUM_WIDTH-1:0] sum_sat;
   logic                        opnd_sgn;
   logic [MAG_W-1:0]            opnd_mag;
   logic [23:0]                 gain_sel;
   logic [15:0]                 chunk_val;
   logic [39:0]                 prod_part;
   logic [CMP_W-1:0]            prod_cmp;
   logic [62:0]                 mag_sat;
   logic signed [63:0]          term_val;
   logic [8:0]                  div_t;
   logic                        div_ge;
   logic [7:0]                  ramp_from;
   logic [15:0]                 ticks_next;
   logic [16:0]                 phase_inc;
   logic [15:0]                 phase_next;
   logic [6:0]                  half_base;
   logic [16:0]                 third;
   htr_pkg::approach_type       appr;

   always_comb begin
      temp_q       = word_ff[15:3];
      deg          = temp_q[12:2];
      bound        = $signed({2'b00, cfg.target_temp}) - $signed({5'b00000, band_ff});
      band_reached = bound[9] || (deg >= {2'b00, bound[8:0]});
      sp_sel       = (cfg.run_mode == htr_pkg::MODE_RAMP) ? setpoint_ff : cfg.target_temp;
      err_wide     = $signed({3'b000, sp_sel, 2'b00}) - $signed({2'b00, temp_q});
      err_new      = err_wide[13:0];
      sum_ext      = {sum_ff[SUM_WIDTH-1], sum_ff}
                   + {{(SUM_WIDTH + 1 - 14){err_new[13]}}, err_new};
      // saturate the integrator at the signed range
      if (sum_ext[SUM_WIDTH] != sum_ext[SUM_WIDTH-1]) begin
         sum_sat = sum_ext[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                      : {1'b0, {(SUM_WIDTH-1){1'b1}}};
      end else begin
         sum_sat = sum_ext[SUM_WIDTH-1:0];
      end

      unique case (ctl.term)
         htr_pkg::TERM_P: begin
            opnd_sgn = err_ff[13];
            opnd_mag = MAG_W'(err_ff[13] ? 14'(-err_ff) : 14'(err_ff));
            gain_sel = cfg.p_gain;
         end
         htr_pkg::TERM_I: begin
            opnd_sgn = sum_ff[SUM_WIDTH-1];
            opnd_mag = MAG_W'(sum_ff[SUM_WIDTH-1] ? SUM_WIDTH'(-sum_ff) : SUM_WIDTH'(sum_ff));
            gain_sel = cfg.i_gain;
         end
         default: begin
            opnd_sgn = dif_ff[14];
            opnd_mag = MAG_W'(dif_ff[14] ? 15'(-dif_ff) : 15'(dif_ff));
            gain_sel = cfg.d_gain;
         end
      endcase
      chunk_val = 16'(opnd_mag >> {ctl.chunk, 4'b0000});
      prod_part = gain_sel * chunk_val;
      prod_cmp  = CMP_W'(prod_ff);
      mag_sat   = (prod_cmp > SAT_MAG) ? SAT_MAG[62:0] : prod_cmp[62:0];
      term_val  = opnd_sgn ? -$signed({1'b0, mag_sat}) : $signed({1'b0, mag_sat});

      div_t      = {rem_ff, quot_ff[15]};
      div_ge     = div_t >= {1'b0, divisor_ff};
      ramp_from  = (deg > 11'd255) ? 8'd255 : deg[7:0];
      ticks_next = ticks_ff + 16'd1;
      phase_inc  = {1'b0, phase_ff} + 17'd1;
      phase_next = ((ticks_next == 16'd0) || (phase_inc == {1'b0, step_ff}))
                 ? 16'd0 : phase_inc[15:0];
      half_base  = (half_ff == WIN_END) ? 7'd0 : half_ff;
      // divide by 393216 as shift by 17 then divide by 3 through reciprocal
      third      = {8'd0, acc_ff[25:17]} * 17'd171;
      appr       = htr_pkg::approach_lookup(cfg.target_temp);

      cmd_in      = cmd_ff;
      word_in     = word_ff;
      started_in  = started_ff;
      sum_in      = sum_ff;
      last_err_in = last_err_ff;
      windup_in   = windup_ff;
      hold_in     = hold_ff;
      band_in     = band_ff;
      setpoint_in = setpoint_ff;
      ticks_in    = ticks_ff;
      phase_in    = phase_ff;
      step_in     = step_ff;
      power_in    = power_ff;
      half_in     = half_ff;
      gate_in     = gate_ff;
      fault_in    = fault_ff;
      err_in      = err_ff;
      dif_in      = dif_ff;
      prod_in     = prod_ff;
      acc_in      = acc_ff;
      quot_in     = quot_ff;
      rem_in      = rem_ff;
      divisor_in  = divisor_ff;

      unique case (ctl.op)
         htr_pkg::OP_NONE: begin
         end
         htr_pkg::OP_LOAD: begin
            cmd_in   = req_cmd;
            word_in  = req_word;
            gate_in  = 1'b0;
            fault_in = 1'b0;
         end
         htr_pkg::OP_FAULT: begin
            fault_in = 1'b1;
            power_in = 7'd0;
         end
         htr_pkg::OP_RESTART, htr_pkg::OP_OFF: begin
            started_in = 1'b0;
            power_in   = 7'd0;
         end
         htr_pkg::OP_CROSS: begin
            gate_in = half_base < power_ff;
            half_in = half_base + 7'd1;
         end
         htr_pkg::OP_FS_START: begin
            sum_in      = '0;
            last_err_in = '0;
            windup_in   = 1'b0;
            hold_in     = appr.hold;
            band_in     = appr.band;
            started_in  = 1'b1;
         end
         htr_pkg::OP_FS_HOLD: begin
            power_in = 7'd0;
            hold_in  = hold_ff - 9'd1;
         end
         htr_pkg::OP_FS_FULL: begin
            power_in = htr_pkg::POWER_MAX;
         end
         htr_pkg::OP_RAMP_START: begin
            sum_in      = '0;
            last_err_in = '0;
            windup_in   = 1'b0;
            ticks_in    = 16'd0;
            phase_in    = 16'd0;
            setpoint_in = (ramp_from < 8'd255) ? ramp_from + 8'd1 : 8'd255;
            divisor_in  = (cfg.target_temp > ramp_from) ? cfg.target_temp - ramp_from : 8'd1;
            quot_in     = cfg.ramp_seconds;
            rem_in      = 8'd0;
            started_in  = 1'b1;
         end
         htr_pkg::OP_DIV_STEP: begin
            rem_in  = div_ge ? 8'(div_t - {1'b0, divisor_ff}) : div_t[7:0];
            quot_in = {quot_ff[14:0], div_ge};
         end
         htr_pkg::OP_DIV_END: begin
            step_in = (quot_ff == 16'd0) ? 16'd1 : quot_ff;
         end
         htr_pkg::OP_RAMP_ADV: begin
            ticks_in = ticks_next;
            phase_in = phase_next;
            if ((phase_next == 16'd0) && (setpoint_ff < cfg.target_temp)) begin
               setpoint_in = setpoint_ff + 8'd1;
            end
         end
         htr_pkg::OP_PID_BEGIN: begin
            if (!windup_ff) begin
               sum_in = sum_sat;
            end
            err_in      = err_new;
            dif_in      = {err_new[13], err_new} - {last_err_ff[13], last_err_ff};
            last_err_in = err_new;
            prod_in     = '0;
            acc_in      = '0;
         end
         htr_pkg::OP_MUL: begin
            prod_in = prod_ff + (PROD_W'(prod_part) << {ctl.chunk, 4'b0000});
         end
         htr_pkg::OP_TERM_END: begin
            acc_in  = acc_ff + term_val;
            prod_in = '0;
         end
         htr_pkg::OP_PID_END: begin
            priority if (acc_ff > htr_pkg::FULL_ACC) begin
               power_in  = htr_pkg::POWER_MAX;
               windup_in = 1'b1;
            end else if (acc_ff < 0) begin
               power_in  = 7'd0;
               windup_in = 1'b1;
            end else begin
               power_in  = third[15:9];
               windup_in = 1'b0;
            end
         end
         default: begin
         end
      endcase

      // run_mode write restarts regulation
      if (mode_wr) begin
         started_in = 1'b0;
         power_in   = 7'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff  <= 1'b0;
         sum_ff      <= '0;
         last_err_ff <= '0;
         windup_ff   <= 1'b0;
         hold_ff     <= 9'd0;
         band_ff     <= 5'd0;
         setpoint_ff <= 8'd0;
         ticks_ff    <= 16'd0;
         phase_ff    <= 16'd0;
         step_ff     <= 16'd1;
         power_ff    <= 7'd0;
         half_ff     <= 7'd0;
         gate_ff     <= 1'b0;
         fault_ff    <= 1'b0;
         cmd_ff      <= 2'd0;
      end else begin
         started_ff  <= started_in;
         sum_ff      <= sum_in;
         last_err_ff <= last_err_in;
         windup_ff   <= windup_in;
         hold_ff     <= hold_in;
         band_ff     <= band_in;
         setpoint_ff <= setpoint_in;
         ticks_ff    <= ticks_in;
         phase_ff    <= phase_in;
         step_ff     <= step_in;
         power_ff    <= power_in;
         half_ff     <= half_in;
         gate_ff     <= gate_in;
         fault_ff    <= fault_in;
         cmd_ff      <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff    <= word_in;
      err_ff     <= err_in;
      dif_ff     <= dif_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   always_comb begin
      status.cmd          = htr_pkg::cmd_type'(cmd_ff);
      status.fault        = word_ff[2];
      status.run_mode     = cfg.run_mode;
      status.started      = started_ff;
      status.band_reached = band_reached;
      status.hold_nz      = hold_ff != 9'd0;
      result.heater_power = power_ff;
      result.gate_on      = gate_ff;
      result.sensor_fault = fault_ff;
      result.ramp_target  = setpoint_ff;
   end

endmodule

`default_nettype wire

// ===== sv/htr_ctrl.sv =====
// Controller of the heater regulator: sequences one item through the datapath.
// Depends on htr_pkg; commands htr_dpath.
`default_nettype none

module htr_ctrl #(
   parameter int SUM_WIDTH = htr_pkg::SUM_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   rsp_free,
   output logic                        out_load,
   input  wire htr_pkg::dp_status_type status,
   output htr_pkg::dp_cmd_type         ctl
);

   localparam int NCH = (SUM_WIDTH + htr_pkg::CHUNK_W - 1) / htr_pkg::CHUNK_W;
   localparam logic [1:0] LAST_CHUNK = 2'(NCH - 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_FS_TEST,
      ST_DIV,
      ST_DIV_END,
      ST_RAMP,
      ST_PID_BEGIN,
      ST_MUL,
      ST_TERM,
      ST_PID_END,
      ST_DONE
   } state_type;

   state_type  state_ff, state_in;
   logic [3:0] div_cnt_ff, div_cnt_in;
   logic [1:0] term_ff, term_in;
   logic [1:0] chunk_ff, chunk_in;

   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      term_in    = term_ff;
      chunk_in   = chunk_ff;
      ctl.op     = htr_pkg::OP_NONE;
      ctl.term   = term_ff;
      ctl.chunk  = chunk_ff;
      req_ready  = 1'b0;
      out_load   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.op   = htr_pkg::OP_LOAD;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (status.cmd)
               htr_pkg::CMD_TICK: begin
                  priority if (status.fault) begin
                     ctl.op   = htr_pkg::OP_FAULT;
                     state_in = ST_DONE;
                  end else if (status.run_mode == htr_pkg::MODE_FULL) begin
                     if (!status.started) ctl.op = htr_pkg::OP_FS_START;
                     state_in = ST_FS_TEST;
                  end else if (status.run_mode == htr_pkg::MODE_RAMP) begin
                     if (!status.started) begin
                        ctl.op     = htr_pkg::OP_RAMP_START;
                        div_cnt_in = 4'd0;
                        state_in   = ST_DIV;
                     end else begin
                        state_in = ST_RAMP;
                     end
                  end else begin
                     ctl.op   = htr_pkg::OP_OFF;
                     state_in = ST_DONE;
                  end
               end
               htr_pkg::CMD_RESTART: begin
                  ctl.op   = htr_pkg::OP_RESTART;
                  state_in = ST_DONE;
               end
               htr_pkg::CMD_CROSS: begin
                  ctl.op   = htr_pkg::OP_CROSS;
                  state_in = ST_DONE;
               end
               htr_pkg::CMD_NOP: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_FS_TEST: begin
            priority if (!status.band_reached) begin
               ctl.op   = htr_pkg::OP_FS_FULL;
               state_in = ST_DONE;
            end else if (status.hold_nz) begin
               ctl.op   = htr_pkg::OP_FS_HOLD;
               state_in = ST_DONE;
            end else begin
               state_in = ST_PID_BEGIN;
            end
         end
         ST_DIV: begin
            ctl.op     = htr_pkg::OP_DIV_STEP;
            div_cnt_in = div_cnt_ff + 4'd1;
            if (div_cnt_ff == htr_pkg::DIV_LAST) state_in = ST_DIV_END;
         end
         ST_DIV_END: begin
            ctl.op   = htr_pkg::OP_DIV_END;
            state_in = ST_RAMP;
         end
         ST_RAMP: begin
            ctl.op   = htr_pkg::OP_RAMP_ADV;
            state_in = ST_PID_BEGIN;
         end
         ST_PID_BEGIN: begin
            ctl.op   = htr_pkg::OP_PID_BEGIN;
            term_in  = htr_pkg::TERM_P;
            chunk_in = 2'd0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            ctl.op = htr_pkg::OP_MUL;
            if (chunk_ff == LAST_CHUNK) begin
               state_in = ST_TERM;
            end else begin
               chunk_in = chunk_ff + 2'd1;
            end
         end
         ST_TERM: begin
            ctl.op = htr_pkg::OP_TERM_END;
            if (term_ff == htr_pkg::TERM_D) begin
               state_in = ST_PID_END;
            end else begin
               term_in  = term_ff + 2'd1;
               chunk_in = 2'd0;
               state_in = ST_MUL;
            end
         end
         ST_PID_END: begin
            ctl.op   = htr_pkg::OP_PID_END;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register can take the result
            if (rsp_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         div_cnt_ff <= 4'd0;
         term_ff    <= 2'd0;
         chunk_ff   <= 2'd0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
         term_ff    <= term_in;
         chunk_ff   <= chunk_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/heater_temperature_regulator_core.sv =====
// Top level of the heater regulator: CSR block, output register, controller and datapath.
// Depends on htr_pkg, htr_req_if, htr_rsp_if, htr_ctrl and htr_dpath.
//
// Usage:
//  - req_chan carries one item per transfer: cmd 0 is a regulation tick with a
//    thermocouple word, cmd 1 restarts regulation, cmd 2 is a mains zero crossing.
//  - rsp_chan returns exactly one result per item: power, gate, fault, ramp target.
//  - The APB port (psel/penable/pwrite/paddr/pwdata) holds six registers at
//    byte address 4*index; write them only while the block is idle.
//  - Restart, crossing and fault items go from decode to the done state and on to
//    the output register; a PID tick runs the shared 24x16 multiplier, which walks
//    each gain product chunk by chunk. The first tick of a ramp also runs the
//    bit-serial divider that computes the step interval.
//  - One item is in work at a time; the next is taken as soon as the result sits
//    in the output register, even while the receiver has not yet taken it.
//  - A stalled receiver holds the result in the output register and the next
//    finished item waits in the controller until the register frees up.
//  - Synchronous reset loads the register defaults, clears regulation state and
//    drops any pending result; no clearing pass is needed.
`default_nettype none

module heater_temperature_regulator_core #(
   parameter int WINDOW_HALF_CYCLES = htr_pkg::WINDOW_HALF_CYCLES_DEF,
   parameter int SUM_WIDTH          = htr_pkg::SUM_WIDTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   htr_req_if.sink          req_chan,
   htr_rsp_if.source        rsp_chan,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   htr_pkg::cfg_type       cfg_ff, cfg_in;
   logic                   mode_wr;
   logic                   csr_write;
   logic [2:0]             csr_index;
   htr_pkg::dp_cmd_type    ctl;
   htr_pkg::dp_status_type status;
   htr_pkg::result_type    result;
   htr_pkg::result_type    rsp_data_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_free;
   logic                   out_load;
   logic                   req_ready;

   // CSR write decode: registers sit on word addresses
   always_comb begin
      pready    = 1'b1;
      csr_write = psel && penable && pwrite;
      csr_index = paddr[4:2];
      cfg_in    = cfg_ff;
      mode_wr   = 1'b0;
      if (csr_write) begin
         unique case (csr_index)
            htr_pkg::REG_RUN_MODE: begin
               cfg_in.run_mode = pwdata[1:0];
               mode_wr         = 1'b1;
            end
            htr_pkg::REG_TARGET_TEMP:  cfg_in.target_temp  = pwdata[7:0];
            htr_pkg::REG_RAMP_SECONDS: cfg_in.ramp_seconds = pwdata[15:0];
            htr_pkg::REG_P_GAIN:       cfg_in.p_gain       = pwdata[23:0];
            htr_pkg::REG_I_GAIN:       cfg_in.i_gain       = pwdata[23:0];
            htr_pkg::REG_D_GAIN:       cfg_in.d_gain       = pwdata[23:0];
            default: begin
            end
         endcase
      end
   end

   // CSR read back
   always_comb begin
      unique case (csr_index)
         htr_pkg::REG_RUN_MODE:     prdata = 32'(cfg_ff.run_mode);
         htr_pkg::REG_TARGET_TEMP:  prdata = 32'(cfg_ff.target_temp);
         htr_pkg::REG_RAMP_SECONDS: prdata = 32'(cfg_ff.ramp_seconds);
         htr_pkg::REG_P_GAIN:       prdata = 32'(cfg_ff.p_gain);
         htr_pkg::REG_I_GAIN:       prdata = 32'(cfg_ff.i_gain);
         htr_pkg::REG_D_GAIN:       prdata = 32'(cfg_ff.d_gain);
         default:                   prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.run_mode     <= htr_pkg::MODE_OFF;
         cfg_ff.target_temp  <= 8'd50;
         cfg_ff.ramp_seconds <= 16'd900;
         cfg_ff.p_gain       <= 24'd1153434;
         cfg_ff.i_gain       <= 24'd13350;
         cfg_ff.d_gain       <= 24'd16609444;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Output register: free when empty or drained by this transfer
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) rsp_data_ff <= result;
   end

   assign req_chan.ready        = req_ready;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.heater_power = rsp_data_ff.heater_power;
   assign rsp_chan.gate_on      = rsp_data_ff.gate_on;
   assign rsp_chan.sensor_fault = rsp_data_ff.sensor_fault;
   assign rsp_chan.ramp_target  = rsp_data_ff.ramp_target;

   htr_ctrl #(
      .SUM_WIDTH (SUM_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_free  (rsp_free),
      .out_load  (out_load),
      .status    (status),
      .ctl       (ctl)
   );

   htr_dpath #(
      .WINDOW_HALF_CYCLES (WINDOW_HALF_CYCLES),
      .SUM_WIDTH          (SUM_WIDTH)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .mode_wr  (mode_wr),
      .req_cmd  (req_chan.cmd),
      .req_word (req_chan.sensor_word),
      .ctl      (ctl),
      .status   (status),
      .result   (result)
   );

`ifndef SYNTHESIS
   // power never leaves the percent range
   a_power_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.heater_power <= htr_pkg::POWER_MAX))
      else $error("heater power above full scale");

   // a result is either a crossing or a tick, never both flags
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.gate_on && rsp_data_ff.sensor_fault))
      else $error("gate and fault flags set together");

   // no second item is taken in the cycle after a transfer
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_ready) |=> !req_ready)
      else $error("request taken while an item is in work");

   // a waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |-> !out_load)
      else $error("result loaded over an untaken result");
`endif

endmodule

`default_nettype wire
